@@ sv/bezier_arc_length_evaluator_assert.svh @@
// assertion macros for the bezier arc length evaluator
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef BEZIER_ARC_LENGTH_EVALUATOR_ASSERT_SVH
`define BEZIER_ARC_LENGTH_EVALUATOR_ASSERT_SVH

// condition must never hold
`define BAE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bae assertion failed");

// antecedent implies consequent in the same cycle
`define BAE_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bae assertion failed");

`endif

@@ sv/bae_pkg.sv @@
// shared constants, widths and enums of the bezier arc length evaluator
// no dependencies
`default_nettype none
package bae_pkg;

  localparam int MAX_SUBDIVISIONS = 64;
  localparam int FRAC_BITS        = 16;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int W_W     = FRAC_BITS + 1;
  localparam int N_W     = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int TOT_W   = DIFF_W + $clog2(MAX_SUBDIVISIONS + 1);
  localparam int DIV_W   = DIFF_W + FRAC_BITS;
  localparam int CNT_W   = $clog2(DIV_W);
  localparam int PROD_W  = DIFF_W + W_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int TW_W    = 17 + FRAC_BITS;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 4;

  localparam logic [3:0] STEP_AXIS_LAST = 4'd11;
  localparam logic [3:0] STEP_FIN_FIRST = 4'd12;
  localparam logic [3:0] STEP_FIN_LAST  = 4'd13;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NDIV, ST_STEP, ST_EVAL, ST_SQ, ST_SQRT, ST_CHORD,
    ST_DECIDE, ST_PEVAL, ST_WDIV, ST_FIN, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OUT_PARAM = 2'd0, OUT_START = 2'd1, OUT_CHORD = 2'd2, OUT_END = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    REG_START_X, REG_START_Y, REG_G1_X, REG_G1_Y,
    REG_G2_X, REG_G2_Y, REG_END_X, REG_END_Y
  } reg_idx_e;

endpackage
`default_nettype wire

@@ sv/bae_if.sv @@
// valid/ready channel interfaces for items in and results out
// no dependencies
`default_nettype none
interface bae_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [16:0]        param_t;
  logic signed [31:0] distance;
  logic [6:0]         subdivisions;
  modport source (output valid, func, param_t, distance, subdivisions, input ready);
  modport sink (input valid, func, param_t, distance, subdivisions, output ready);
endinterface

interface bae_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [31:0]        curve_length;
  logic [1:0]         outcome;
  modport source (output valid, point_x, point_y, curve_length, outcome, input ready);
  modport sink (input valid, point_x, point_y, curve_length, outcome, output ready);
endinterface
`default_nettype wire

@@ sv/bezier_arc_length_evaluator.sv @@
// cubic bezier evaluator with chord based arc length, one item at a time
// depends on bae_pkg, bae_if and bezier_arc_length_evaluator_assert.svh
//
// channel   dir  handshake        contents
// in_if     in   valid/ready      func, param_t, distance, subdivisions
// out_if    out  valid/ready      point_x, point_y, curve_length, outcome
// cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i (control points)
//
// one shared lerp unit (multiply, then add) does all de casteljau work, product registered
// a chord: the step, the lerps of both axes, the squaring, 33 root bits, the chord update
// parameter mode: a pass over all chords for the length, then the point at param_t
// distance mode: clamped to start or end, else a second pass up to the chord that is hit
// in_if.ready only in idle; the result is held until out_if.ready
// asynchronous active low reset clears the sequencer and the control points
`default_nettype none
module bezier_arc_length_evaluator (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [bae_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [31:0]                     cfg_data_i,
  bae_in_if.sink                         in_if,
  bae_out_if.source                      out_if
);
  import bae_pkg::*;

  logic signed [COORD_W-1:0] cp_q [NUM_REGS];

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [3:0]       step_q;
  logic             phase_q;
  logic             pass_q;
  logic [N_W-1:0]   i_q, n_q;

  logic             func_q;
  logic [W_W-1:0]   tw_q;
  logic signed [31:0] dist_q;

  logic [W_W-1:0]   q0_q, qacc_q;
  logic [N_W-1:0]   r0_q, racc_q;
  logic [TOT_W-1:0] total_q, trav_q;
  logic [W_W-1:0]   wfin_q;
  outcome_e         outcome_q;

  logic signed [COORD_W-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q, fin_x_q, fin_y_q;
  logic signed [COORD_W-1:0] ta_q, tb_q, tc_q, td_q, te_q;
  logic signed [PROD_W-1:0]  prod_q;

  logic [SQ_W-1:0]   m_q, rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  logic [DIV_W-1:0]  dnum_q, dquo_q;
  logic [DIFF_W-1:0] dden_q;
  logic [DIFF_W:0]   drem_q;

  // lerp operand selection
  logic signed [COORD_W-1:0] la, lb;
  logic [W_W-1:0]            lw;
  logic [3:0]                sstep;
  logic                      axis;
  always_comb begin
    axis  = (step_q > 4'd5) && (step_q <= STEP_AXIS_LAST);
    sstep = axis ? step_q - 4'd6 : step_q;
    la = '0;
    lb = '0;
    case (sstep)
      4'd0: begin la = cp_q[{2'b00, axis}]; lb = cp_q[{2'b01, axis}]; end
      4'd1: begin la = cp_q[{2'b01, axis}]; lb = cp_q[{2'b10, axis}]; end
      4'd2: begin la = cp_q[{2'b10, axis}]; lb = cp_q[{2'b11, axis}]; end
      4'd3: begin la = ta_q; lb = tb_q; end
      4'd4: begin la = tb_q; lb = tc_q; end
      4'd5: begin la = td_q; lb = te_q; end
      STEP_FIN_FIRST: begin la = prev_x_q; lb = cur_x_q; end
      STEP_FIN_LAST:  begin la = prev_y_q; lb = cur_y_q; end
      default: begin la = '0; lb = '0; end
    endcase
    case (state_q)
      ST_PEVAL: lw = tw_q;
      ST_FIN:   lw = wfin_q;
      default:  lw = qacc_q;
    endcase
  end

  logic signed [DIFF_W-1:0]  ldiff;
  logic signed [PROD_W-1:0]  lprod, lrnd;
  logic signed [COORD_W-1:0] lres;
  always_comb begin
    ldiff = DIFF_W'(lb) - DIFF_W'(la);
    lprod = PROD_W'(ldiff) * $signed({{(PROD_W-W_W){1'b0}}, lw});
    lrnd  = (prod_q + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    lres  = la + lrnd[COORD_W-1:0];
  end

  // squaring operand
  logic signed [DIFF_W-1:0] sdx;
  logic [DIFF_W-1:0]        sabs;
  always_comb begin
    sdx  = (cnt_q == '0) ? DIFF_W'(cur_x_q) - DIFF_W'(prev_x_q)
                         : DIFF_W'(cur_y_q) - DIFF_W'(prev_y_q);
    sabs = sdx[DIFF_W-1] ? DIFF_W'(-sdx) : DIFF_W'(sdx);
  end

  // one root bit
  logic [REM_W+1:0] rwide;
  logic [REM_W+1:0] rcand;
  logic             rge;
  always_comb begin
    rwide = {rem_q, rad_q[SQ_W-1 -: 2]};
    rcand = (REM_W+2)'({root_q, 2'b01});
    rge   = rwide >= rcand;
  end

  // one quotient bit
  logic [DIFF_W+1:0] dwide;
  logic              dge;
  always_comb begin
    dwide = {drem_q, dnum_q[DIV_W-1]};
    dge   = dwide >= (DIFF_W+2)'(dden_q);
  end

  // chord decisions
  logic [TOT_W-1:0] seg, trav_seg, dist_u;
  logic             hit;
  logic [N_W:0]     rsum;
  always_comb begin
    seg      = TOT_W'(root_q);
    trav_seg = trav_q + seg;
    dist_u   = TOT_W'(dist_q[30:0]) | (TOT_W'(dist_q[31]) << 31);
    hit      = dist_u <= trav_seg;
    rsum     = (N_W+1)'(racc_q) + (N_W+1)'(r0_q);
  end

  logic [N_W-1:0] n_clamp;
  logic [16:0]    t_clamp;
  logic [TW_W-1:0] t_sh;
  always_comb begin
    if (in_if.subdivisions == 7'd0) begin
      n_clamp = N_W'(1);
    end else if (32'(in_if.subdivisions) > 32'(MAX_SUBDIVISIONS)) begin
      n_clamp = N_W'(MAX_SUBDIVISIONS);
    end else begin
      n_clamp = N_W'(in_if.subdivisions);
    end
    t_clamp = (in_if.param_t > 17'd65536) ? 17'd65536 : in_if.param_t;
    t_sh    = (TW_W'(t_clamp) << FRAC_BITS) >> 16;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_if.valid) state_d = ST_NDIV;
      ST_NDIV:   if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_STEP;
      ST_STEP:   state_d = ST_EVAL;
      ST_EVAL:   if (step_q == STEP_AXIS_LAST && phase_q) state_d = ST_SQ;
      ST_SQ:     if (cnt_q == CNT_W'(2)) state_d = ST_SQRT;
      ST_SQRT:   if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = ST_CHORD;
      ST_CHORD: begin
        if (!pass_q) begin
          state_d = (i_q == n_q) ? ST_DECIDE : ST_STEP;
        end else if (hit) begin
          state_d = (root_q != '0) ? ST_WDIV : ST_FIN;
        end else begin
          state_d = (i_q == n_q) ? ST_DONE : ST_STEP;
        end
      end
      ST_DECIDE: begin
        if (!func_q) state_d = ST_PEVAL;
        else if (dist_q <= 0) state_d = ST_DONE;
        else if (dist_u >= total_q) state_d = ST_DONE;
        else state_d = ST_STEP;
      end
      ST_PEVAL:  if (step_q == STEP_AXIS_LAST && phase_q) state_d = ST_DONE;
      ST_WDIV:   if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_FIN;
      ST_FIN:    if (step_q == STEP_FIN_LAST && phase_q) state_d = ST_DONE;
      ST_DONE:   if (out_if.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_if.ready  = (state_q == ST_IDLE);
    out_if.valid = (state_q == ST_DONE);
    case (outcome_q)
      OUT_PARAM: begin out_if.point_x = cur_x_q; out_if.point_y = cur_y_q; end
      OUT_START: begin
        out_if.point_x = cp_q[REG_START_X]; out_if.point_y = cp_q[REG_START_Y];
      end
      OUT_CHORD: begin out_if.point_x = fin_x_q; out_if.point_y = fin_y_q; end
      default: begin
        out_if.point_x = cp_q[REG_END_X]; out_if.point_y = cp_q[REG_END_Y];
      end
    endcase
    out_if.curve_length = (total_q[TOT_W-1:32] != '0) ? 32'hFFFF_FFFF : total_q[31:0];
    out_if.outcome      = outcome_q;
  end

  // control point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) cp_q[k] <= '0;
    end else if (cfg_we_i && cfg_idx_i < CFG_IDX_W'(NUM_REGS)) begin
      cp_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      phase_q <= 1'b0;
      pass_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
      if (state_d == ST_FIN && state_q != ST_FIN) begin
        step_q  <= STEP_FIN_FIRST;
        phase_q <= 1'b0;
      end else if (state_d != state_q) begin
        step_q  <= '0;
        phase_q <= 1'b0;
      end else if (state_q == ST_EVAL || state_q == ST_PEVAL || state_q == ST_FIN) begin
        phase_q <= !phase_q;
        if (phase_q) step_q <= step_q + 4'd1;
      end
      case (state_q)
        ST_IDLE:   if (in_if.valid) begin pass_q <= 1'b0; i_q <= '0; end
        ST_STEP:   i_q <= i_q + N_W'(1);
        ST_DECIDE: if (state_d == ST_STEP) begin pass_q <= 1'b1; i_q <= '0; end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        func_q   <= in_if.func;
        tw_q     <= t_sh[W_W-1:0];
        dist_q   <= in_if.distance;
        n_q      <= n_clamp;
        qacc_q   <= '0;
        racc_q   <= '0;
        total_q  <= '0;
        trav_q   <= '0;
        prev_x_q <= cp_q[REG_START_X];
        prev_y_q <= cp_q[REG_START_Y];
        dnum_q   <= DIV_W'(1) << FRAC_BITS;
        dden_q   <= DIFF_W'(n_clamp);
        drem_q   <= '0;
        dquo_q   <= '0;
      end
      ST_NDIV, ST_WDIV: begin
        dnum_q <= dnum_q << 1;
        if (dge) begin
          drem_q <= (DIFF_W+1)'(dwide - (DIFF_W+2)'(dden_q));
          dquo_q <= {dquo_q[DIV_W-2:0], 1'b1};
        end else begin
          drem_q <= dwide[DIFF_W:0];
          dquo_q <= {dquo_q[DIV_W-2:0], 1'b0};
        end
        if (state_d != state_q) begin
          q0_q   <= dge ? {dquo_q[W_W-2:0], 1'b1} : {dquo_q[W_W-2:0], 1'b0};
          r0_q   <= dge ? N_W'(dwide - (DIFF_W+2)'(dden_q)) : N_W'(dwide);
          wfin_q <= dge ? {dquo_q[W_W-2:0], 1'b1} : {dquo_q[W_W-2:0], 1'b0};
        end
      end
      ST_STEP: begin
        if (rsum >= (N_W+1)'(n_q)) begin
          racc_q <= N_W'(rsum - (N_W+1)'(n_q));
          qacc_q <= qacc_q + q0_q + W_W'(1);
        end else begin
          racc_q <= N_W'(rsum);
          qacc_q <= qacc_q + q0_q;
        end
      end
      ST_EVAL, ST_PEVAL, ST_FIN: begin
        if (!phase_q) begin
          prod_q <= lprod;
        end else begin
          case (step_q)
            4'd0, 4'd6: ta_q <= lres;
            4'd1, 4'd7: tb_q <= lres;
            4'd2, 4'd8: tc_q <= lres;
            4'd3, 4'd9: td_q <= lres;
            4'd4, 4'd10: te_q <= lres;
            4'd5: cur_x_q <= lres;
            STEP_AXIS_LAST: cur_y_q <= lres;
            STEP_FIN_FIRST: fin_x_q <= lres;
            STEP_FIN_LAST:  fin_y_q <= lres;
            default: ;
          endcase
        end
      end
      ST_SQ: begin
        m_q <= SQ_W'(sabs) * SQ_W'(sabs);
        if (cnt_q == CNT_W'(1)) rad_q <= m_q;
        if (cnt_q == CNT_W'(2)) begin
          rad_q  <= rad_q + m_q;
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        rad_q <= rad_q << 2;
        if (rge) begin
          rem_q  <= REM_W'(rwide - rcand);
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= REM_W'(rwide);
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      ST_CHORD: begin
        if (!pass_q) begin
          total_q  <= total_q + seg;
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
        end else if (hit) begin
          outcome_q <= OUT_CHORD;
          wfin_q    <= '0;
          dnum_q    <= {DIFF_W'(dist_u - trav_q), {FRAC_BITS{1'b0}}};
          dden_q    <= root_q;
          drem_q    <= '0;
          dquo_q    <= '0;
        end else begin
          trav_q   <= trav_seg;
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
          outcome_q <= OUT_END;
        end
      end
      ST_DECIDE: begin
        qacc_q   <= '0;
        racc_q   <= '0;
        trav_q   <= '0;
        prev_x_q <= cp_q[REG_START_X];
        prev_y_q <= cp_q[REG_START_Y];
        if (!func_q) outcome_q <= OUT_PARAM;
        else if (dist_q <= 0) outcome_q <= OUT_START;
        else outcome_q <= OUT_END;
      end
      default: ;
    endcase
  end

  `include "bezier_arc_length_evaluator_assert.svh"

  `BAE_NEVER(a_hs_excl, in_if.ready && out_if.valid)
  `BAE_IMPLIES(a_chord_dist, out_if.valid && outcome_q == OUT_CHORD, func_q && pass_q)
  `BAE_NEVER(a_idx_bound, state_q != ST_IDLE && i_q > n_q)
  `BAE_IMPLIES(a_param_mode, out_if.valid && !func_q, outcome_q == OUT_PARAM)

endmodule
`default_nettype wire
